// ----- rtl/tfse_pkg.sv -----
// package for the trainer frame stuffing encoder
// holds frame constants, microcode word layout and the control program
// no dependencies
package tfse_pkg;

    localparam int CHANNEL_COUNT = 8;
    localparam int CHAN_W        = 12;
    localparam int PAIR_COUNT    = (CHANNEL_COUNT + 1) / 2;
    localparam int PAIR_W        = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] TYPE_BYTE = 8'h80;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [2:0]        t_step;

    localparam t_step STEP_IDLE = 3'd0;
    localparam t_step STEP_FLAG = 3'd1;
    localparam t_step STEP_TYPE = 3'd2;
    localparam t_step STEP_DATA = 3'd3;
    localparam t_step STEP_CSUM = 3'd4;
    localparam t_step STEP_END  = 3'd5;

    typedef enum logic [1:0] {
        SRC_FLAG,
        SRC_TYPE,
        SRC_DATA,
        SRC_CSUM
    } t_src;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_DATA_MORE,
        JMP_ALWAYS
    } t_jmp;

    typedef struct packed {
        logic  emit;
        t_src  src;
        logic  stuff;
        logic  frame_end;
        t_jmp  jmp;
        t_step target;
    } t_ucode;

    typedef struct packed {
        t_ucode word;
        logic   load;
    } t_ctrl;

    typedef struct packed {
        logic adv;
        logic hold;
        logic data_last;
    } t_status;

    function automatic t_ucode ucode_rom(input t_step step);
        t_ucode w;
        begin
            unique case (step)
                STEP_IDLE: w = '{1'b0, SRC_FLAG, 1'b0, 1'b0, JMP_WAIT_IN,   STEP_FLAG};
                STEP_FLAG: w = '{1'b1, SRC_FLAG, 1'b0, 1'b0, JMP_NEXT,      STEP_IDLE};
                STEP_TYPE: w = '{1'b1, SRC_TYPE, 1'b1, 1'b0, JMP_NEXT,      STEP_IDLE};
                STEP_DATA: w = '{1'b1, SRC_DATA, 1'b1, 1'b0, JMP_DATA_MORE, STEP_DATA};
                STEP_CSUM: w = '{1'b1, SRC_CSUM, 1'b0, 1'b0, JMP_NEXT,      STEP_IDLE};
                STEP_END:  w = '{1'b1, SRC_FLAG, 1'b0, 1'b1, JMP_ALWAYS,    STEP_IDLE};
                default:   w = '{1'b0, SRC_FLAG, 1'b0, 1'b0, JMP_ALWAYS,    STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

// ----- rtl/tfse_sequencer.sv -----
// microcode sequencer: step counter, control rom lookup and jump logic
// depends on tfse_pkg
module tfse_sequencer import tfse_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_ctrl   o_ctrl,
    output logic    o_in_stall
);

    t_step  r_step;
    t_step  n_step;
    t_ucode w_word;

    always_comb begin
        w_word = ucode_rom(r_step);
        n_step = r_step;
        if (w_word.jmp == JMP_WAIT_IN) begin
            if (i_in_valid) begin
                n_step = w_word.target;
            end
        end else if (i_status.adv && !i_status.hold) begin
            if (w_word.jmp == JMP_ALWAYS) begin
                n_step = w_word.target;
            end else if (w_word.jmp == JMP_DATA_MORE && !i_status.data_last) begin
                n_step = w_word.target;
            end else begin
                n_step = r_step + 3'd1;
            end
        end
    end

    always_comb begin
        o_ctrl.word = w_word;
        o_ctrl.load = (w_word.jmp == JMP_WAIT_IN) && i_in_valid;
        o_in_stall  = (w_word.jmp != JMP_WAIT_IN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ----- rtl/tfse_datapath.sv -----
// datapath: channel pair shift line, byte packing, escaping, checksum, output register
// depends on tfse_pkg
module tfse_datapath import tfse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chan       i_chan [CHANNEL_COUNT],
    input  t_ctrl       i_ctrl,
    input  logic        i_out_stall,
    output t_status     o_status,
    output logic        o_out_valid,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end
);

    t_chan             r_pa [PAIR_COUNT];
    t_chan             r_pb [PAIR_COUNT];
    logic [PAIR_W-1:0] r_pair;
    logic [1:0]        r_sub;
    logic              r_esc;
    logic [7:0]        r_csum;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_end;

    logic              w_adv;
    logic [7:0]        w_data;
    logic [7:0]        w_raw;
    logic              w_need_esc;
    logic [7:0]        w_byte;
    logic              w_fire;
    logic              w_data_last;

    always_comb begin
        case (r_sub)
            2'd0:    w_data = r_pa[0][7:0];
            2'd1:    w_data = {r_pa[0][11:8], r_pb[0][7:4]};
            default: w_data = {r_pb[0][3:0], r_pb[0][11:8]};
        endcase
        case (i_ctrl.word.src)
            SRC_FLAG: w_raw = FLAG_BYTE;
            SRC_TYPE: w_raw = TYPE_BYTE;
            SRC_DATA: w_raw = w_data;
            default:  w_raw = r_csum;
        endcase
        w_adv       = !r_out_valid || !i_out_stall;
        w_fire      = w_adv && i_ctrl.word.emit;
        w_need_esc  = i_ctrl.word.stuff && !r_esc
                      && (w_raw == FLAG_BYTE || w_raw == ESC_BYTE);
        w_byte      = w_need_esc ? ESC_BYTE : (r_esc ? (w_raw ^ ESC_XOR) : w_raw);
        w_data_last = (r_pair == PAIR_W'(PAIR_COUNT - 1)) && (r_sub == 2'd2);
        o_status.adv       = w_adv;
        o_status.hold      = w_need_esc;
        o_status.data_last = w_data_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            for (int p = 0; p < PAIR_COUNT; p++) begin
                r_pa[p] <= i_chan[2*p];
                if (2*p + 1 < CHANNEL_COUNT) begin
                    r_pb[p] <= i_chan[(2*p + 1) % CHANNEL_COUNT];
                end else begin
                    r_pb[p] <= '0;
                end
            end
        end else if (w_fire && i_ctrl.word.src == SRC_DATA && !w_need_esc
                     && r_sub == 2'd2) begin
            for (int p = 0; p < PAIR_COUNT - 1; p++) begin
                r_pa[p] <= r_pa[p + 1];
                r_pb[p] <= r_pb[p + 1];
            end
        end
        if (w_adv) begin
            r_out_byte <= w_byte;
            r_out_end  <= i_ctrl.word.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair      <= '0;
            r_sub       <= '0;
            r_esc       <= 1'b0;
            r_csum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= i_ctrl.word.emit;
            end
            if (i_ctrl.load) begin
                r_pair <= '0;
                r_sub  <= '0;
                r_esc  <= 1'b0;
            end else if (w_fire) begin
                r_esc <= w_need_esc;
                if (i_ctrl.word.src == SRC_FLAG && !i_ctrl.word.frame_end) begin
                    r_csum <= '0;
                end else if (i_ctrl.word.stuff && !r_esc) begin
                    r_csum <= r_csum ^ w_raw;
                end
                if (i_ctrl.word.src == SRC_DATA && !w_need_esc) begin
                    if (r_sub == 2'd2) begin
                        r_sub  <= '0;
                        r_pair <= r_pair + PAIR_W'(1);
                    end else begin
                        r_sub <= r_sub + 2'd1;
                    end
                end
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_end  = r_out_end;

endmodule

// ----- rtl/trainer_frame_stuffing_encoder.sv -----
// top level of the trainer frame stuffing encoder
// depends on tfse_pkg, tfse_sequencer and tfse_datapath
//
// Takes eight 12-bit channels per request and sends one frame per request
// on the output: 0x7E, type 0x80, three packed bytes per channel pair,
// XOR checksum (sent raw) and a closing 0x7E flagged by o_frame_end. Type and
// data bytes equal to 0x7E or 0x7D go out as 0x7D then the byte XOR 0x20.
// A frame is 16 to 28 bytes; a microcoded step counter emits one byte per cycle
// when the output is not stalled, and a new request is taken in the idle step
// after the last byte is loaded into the output register.
module trainer_frame_stuffing_encoder import tfse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [11:0] i_channel_0,
    input  logic [11:0] i_channel_1,
    input  logic [11:0] i_channel_2,
    input  logic [11:0] i_channel_3,
    input  logic [11:0] i_channel_4,
    input  logic [11:0] i_channel_5,
    input  logic [11:0] i_channel_6,
    input  logic [11:0] i_channel_7,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end
);

    t_chan   w_chan [CHANNEL_COUNT];
    t_ctrl   w_ctrl;
    t_status w_status;

    always_comb begin
        w_chan[0] = i_channel_0;
        w_chan[1] = i_channel_1;
        w_chan[2] = i_channel_2;
        w_chan[3] = i_channel_3;
        w_chan[4] = i_channel_4;
        w_chan[5] = i_channel_5;
        w_chan[6] = i_channel_6;
        w_chan[7] = i_channel_7;
    end

    tfse_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl),
        .o_in_stall (o_in_stall)
    );

    tfse_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_chan       (w_chan),
        .i_ctrl       (w_ctrl),
        .i_out_stall  (i_out_stall),
        .o_status     (w_status),
        .o_out_valid  (o_out_valid),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end)
    );

endmodule

// ----- sim/tfse_frame_checker.sv -----
// frame checker for the trainer frame stuffing encoder testbench
// watches both channels, predicts each frame byte by byte and compares
// depends on tfse_pkg
module tfse_frame_checker import tfse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [11:0] i_channel_0,
    input  logic [11:0] i_channel_1,
    input  logic [11:0] i_channel_2,
    input  logic [11:0] i_channel_3,
    input  logic [11:0] i_channel_4,
    input  logic [11:0] i_channel_5,
    input  logic [11:0] i_channel_6,
    input  logic [11:0] i_channel_7,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_end,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_frame_byte;

    t_frame_byte expected_bytes[$];
    int          fail_count    = 0;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    task automatic stuff_byte(input logic [7:0] b, inout logic [7:0] csum);
        csum = csum ^ b;
        if (b == FLAG_BYTE || b == ESC_BYTE) begin
            expected_bytes.push_back('{ESC_BYTE, 1'b0});
            b = b ^ ESC_XOR;
        end
        expected_bytes.push_back('{b, 1'b0});
    endtask

    task automatic encode_frame(input t_chan chans [CHANNEL_COUNT]);
        logic [7:0] csum;
        t_chan      a;
        t_chan      b;
        csum = '0;
        expected_bytes.push_back('{FLAG_BYTE, 1'b0});
        stuff_byte(TYPE_BYTE, csum);
        for (int p = 0; p < PAIR_COUNT; p++) begin
            a = chans[2*p];
            b = (2*p + 1 < CHANNEL_COUNT) ? chans[2*p + 1] : '0;
            stuff_byte(a[7:0], csum);
            stuff_byte({a[11:8], b[7:4]}, csum);
            stuff_byte({b[3:0], b[11:8]}, csum);
        end
        // checksum goes out raw
        expected_bytes.push_back('{csum, 1'b0});
        expected_bytes.push_back('{FLAG_BYTE, 1'b1});
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_byte want;
        t_chan       chans [CHANNEL_COUNT];
        if (!i_rst_n) begin
            expected_bytes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("byte %h with no frame pending", i_frame_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_frame_byte !== want.value) begin
                        report_mismatch($sformatf("frame_byte %h, expected %h",
                                                  i_frame_byte, want.value));
                    end
                    if (i_frame_end !== want.last) begin
                        report_mismatch($sformatf("frame_end %b, expected %b on byte %h",
                                                  i_frame_end, want.last, want.value));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                chans = '{i_channel_0, i_channel_1, i_channel_2, i_channel_3,
                          i_channel_4, i_channel_5, i_channel_6, i_channel_7};
                encode_frame(chans);
            end
        end
        pending_count = expected_bytes.size();
    end

endmodule

// ----- sim/testbench.sv -----
// top of the trainer frame stuffing encoder testbench
// drives channel requests and output stalls, gives the verdict
// depends on tfse_pkg, tfse_frame_checker and the encoder rtl
module testbench;
    import tfse_pkg::*;

    localparam int RANDOM_ITEMS   = 93;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        req_valid  = 1'b0;
    logic        req_stall;
    t_chan       chan [CHANNEL_COUNT] = '{default: '0};
    logic        byte_valid;
    logic        byte_stall = 1'b0;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic        calm       = 1'b1;
    int          fail_count;
    int          pending;
    int          stall_left = 0;
    int          idle_cycles = 0;

    always #4 clk = ~clk;

    trainer_frame_stuffing_encoder i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .o_in_stall   (req_stall),
        .i_channel_0  (chan[0]),
        .i_channel_1  (chan[1]),
        .i_channel_2  (chan[2]),
        .i_channel_3  (chan[3]),
        .i_channel_4  (chan[4]),
        .i_channel_5  (chan[5]),
        .i_channel_6  (chan[6]),
        .i_channel_7  (chan[7]),
        .o_out_valid  (byte_valid),
        .i_out_stall  (byte_stall),
        .o_frame_byte (frame_byte),
        .o_frame_end  (frame_end)
    );

    tfse_frame_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .i_in_stall   (req_stall),
        .i_channel_0  (chan[0]),
        .i_channel_1  (chan[1]),
        .i_channel_2  (chan[2]),
        .i_channel_3  (chan[3]),
        .i_channel_4  (chan[4]),
        .i_channel_5  (chan[5]),
        .i_channel_6  (chan[6]),
        .i_channel_7  (chan[7]),
        .i_out_valid  (byte_valid),
        .i_out_stall  (byte_stall),
        .i_frame_byte (frame_byte),
        .i_frame_end  (frame_end),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic t_chan random_channel();
        t_chan escape_heavy [4] = '{12'h77E, 12'hEE7, 12'h77D, 12'hDD7};
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            1: return {4'($urandom_range(0, 15)), ($urandom_range(0, 1) ? 8'h7E : 8'h7D)};
            2: return escape_heavy[$urandom_range(0, 3)];
            default: return 12'($urandom());
        endcase
    endfunction

    task automatic send_request(input t_chan vals [CHANNEL_COUNT]);
        int gap;
        req_valid <= 1'b1;
        foreach (vals[i]) chan[i] <= vals[i];
        do @(posedge clk); while (req_stall);
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_pairs(input t_chan a, input t_chan b);
        t_chan vals [CHANNEL_COUNT];
        foreach (vals[i]) vals[i] = (i % 2 == 0) ? a : b;
        send_request(vals);
    endtask

    task automatic send_checksum_case(input t_chan first);
        t_chan vals [CHANNEL_COUNT];
        foreach (vals[i]) vals[i] = '0;
        vals[0] = first;
        send_request(vals);
    endtask

    // output side back-pressure
    always @(posedge clk) begin
        if (!rst_n || calm) begin
            stall_left = 0;
            byte_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            byte_stall <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            byte_stall <= 1'b1;
        end else begin
            byte_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (byte_valid && !byte_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: nothing accepted for %0d cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        t_chan vals [CHANNEL_COUNT];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every escape position, raw checksum on flag values
        send_pairs(12'h000, 12'h000);
        send_pairs(12'hFFF, 12'hFFF);
        send_pairs(12'hAAA, 12'h555);
        send_pairs(12'h555, 12'hAAA);
        send_pairs(12'h77E, 12'hEE7);
        send_pairs(12'h77D, 12'hDD7);
        send_pairs(12'h07E, 12'h000);
        send_pairs(12'h700, 12'h0E0);
        send_pairs(12'h000, 12'hE07);
        send_pairs(12'h07D, 12'hD07);
        send_pairs(12'h700, 12'h0D0);
        send_checksum_case(12'h0FE);
        send_checksum_case(12'h0FD);
        send_checksum_case(12'hFFE);
        foreach (vals[i]) vals[i] = t_chan'(i * 12'h111);
        send_request(vals);
        calm <= 1'b0;
        send_pairs(12'h77E, 12'hDD7);
        send_pairs(12'hFFF, 12'h000);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            calm <= (k >= 40 && k < 55);
            foreach (vals[i]) vals[i] = random_channel();
            send_request(vals);
        end
        req_valid <= 1'b0;
        calm      <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tfse_pkg.sv
rtl/tfse_sequencer.sv
rtl/tfse_datapath.sv
rtl/trainer_frame_stuffing_encoder.sv
sim/tfse_frame_checker.sv
sim/testbench.sv
